>>> rtl/gsa_pkg.sv
// Shared types and constants for the grouped standard deviation accumulator.
// Holds the transaction payloads, status codes and sequencer states.
// No dependencies; compile before every other file of the block.
package gsa_pkg;

	// Default bound on classes per series
	localparam int MAX_CLASSES_DEF = 256;

	// Field widths
	localparam int IN_W     = 16;
	localparam int D_W      = IN_W + 1;
	localparam int MEAN_W   = 24;
	localparam int SD_W     = 24;
	localparam int STATUS_W = 2;

	// Per-class multiplier: 34 x 17 signed
	localparam int MUL_A_W = 2 * D_W;
	localparam int MUL_B_W = D_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Q.8 scaling: mean numerator is S1 << 7, root argument is variance << 16
	localparam int MEAN_FRAC_SHIFT = 7;
	localparam int SD_FRAC_SHIFT   = 16;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_ZERO_FREQ = 2'd1,
		STAT_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [IN_W-1:0] class_lo;
		logic signed [IN_W-1:0] class_hi;
		logic [IN_W-1:0]        frequency;
		logic                   last_class;
	} class_t;

	typedef struct packed {
		logic signed [MEAN_W-1:0] mean_q8;
		logic [SD_W-1:0]          stddev_q8;
		logic [STATUS_W-1:0]      status;
	} result_t;

	// Accumulator sequencer
	typedef enum logic [2:0] {
		A_IDLE,
		A_FD,
		A_SQ,
		A_FDD,
		A_S2,
		A_FIN,
		A_EMIT
	} acc_state_t;

	// Final arithmetic sequencer
	typedef enum logic [3:0] {
		F_IDLE,
		F_MUL_A,
		F_MUL_B,
		F_DIFF,
		F_SQRT,
		F_DIV_M,
		F_FIX_M,
		F_DIV_S,
		F_DONE
	} fin_state_t;

endpackage

>>> rtl/gsa_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// The payload type is set at instantiation; no package dependency.
interface gsa_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/gsa_finish.sv
// End-of-series arithmetic: S0*S2 - S1*S1, integer square root and the two
// divisions, all on one shared add/subtract unit. Depends on gsa_pkg.
module gsa_finish #(
	parameter int MAX_CLASSES = gsa_pkg::MAX_CLASSES_DEF,
	localparam int LOG_W = $clog2(MAX_CLASSES),
	localparam int S0_W  = gsa_pkg::IN_W + LOG_W,
	localparam int S1_W  = 2 * gsa_pkg::IN_W + 1 + LOG_W,
	localparam int S2_W  = 3 * gsa_pkg::IN_W + 1 + LOG_W
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [S0_W-1:0]                  s0,
	input  logic signed [S1_W-1:0]           s1,
	input  logic [S2_W-1:0]                  s2,
	output logic                             done,
	output logic signed [gsa_pkg::MEAN_W-1:0] mean_q8,
	output logic [gsa_pkg::SD_W-1:0]         stddev_q8
);
	import gsa_pkg::*;

	localparam int MAG_W   = S1_W;
	localparam int A_W     = S0_W + S2_W;
	localparam int B_W     = 2 * MAG_W;
	localparam int P_W     = (A_W > B_W) ? A_W : B_W;
	localparam int X_RAW_W = P_W + SD_FRAC_SHIFT;
	localparam int X_W     = X_RAW_W + (X_RAW_W % 2);
	localparam int R_W     = X_W / 2;
	localparam int NUM_W   = MAG_W + MEAN_FRAC_SHIFT;
	localparam int DVD_W   = (NUM_W > R_W) ? NUM_W : R_W;
	localparam int DVS_W   = S0_W + 1;
	localparam int REM_W   = S0_W + 2;
	localparam int ALU_T_W = (P_W > R_W + 2) ? P_W : R_W + 2;
	localparam int ALU_W   = (ALU_T_W > REM_W) ? ALU_T_W : REM_W;
	localparam int STEP_T  = (MAG_W > R_W) ? MAG_W : R_W;
	localparam int STEP_MAX = (STEP_T > DVD_W) ? STEP_T : DVD_W;
	localparam int STEP_W  = $clog2(STEP_MAX + 1);

	localparam logic [STEP_W-1:0] LAST_MUL_A = STEP_W'(S0_W - 1);
	localparam logic [STEP_W-1:0] LAST_MUL_B = STEP_W'(MAG_W - 1);
	localparam logic [STEP_W-1:0] LAST_SQRT  = STEP_W'(R_W - 1);
	localparam logic [STEP_W-1:0] LAST_DIV   = STEP_W'(DVD_W - 1);

	fin_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic step_end;

	logic [MAG_W-1:0] mplr_q;
	logic [MAG_W-1:0] mag_q;
	logic             neg_q;
	logic [P_W-1:0]   acc_q;
	logic [P_W-1:0]   a_q;
	logic [X_W-1:0]   x_q;
	logic [R_W+1:0]   rem_q;
	logic [R_W-1:0]   root_q;
	logic [DVD_W-1:0] dvd_q;
	logic [REM_W-1:0] drem_q;
	logic [DVS_W-1:0] dvs_q;
	logic signed [MEAN_W-1:0] mean_q;

	logic [MAG_W-1:0]  mag_in;
	logic [R_W+1:0]    rem_sh;
	logic [R_W+1:0]    trial;
	logic [REM_W-1:0]  drem_sh;
	logic [MEAN_W-1:0] q_low;
	logic [MEAN_W-1:0] q_up;
	logic [MEAN_W-1:0] mean_next;

	logic [ALU_W-1:0] alu_a, alu_b;
	logic             alu_sub;
	logic [ALU_W:0]   alu_y;
	logic             alu_ge;

	// Magnitude and sign of S1
	assign mag_in = s1[S1_W-1] ? (MAG_W'(~s1) + MAG_W'(1)) : MAG_W'(s1);

	// Root step: bring down two bits, try (root << 2) | 1
	assign rem_sh = {rem_q[R_W-1:0], x_q[X_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	// Division step: bring down one dividend bit
	assign drem_sh = {drem_q[REM_W-2:0], dvd_q[DVD_W-1]};

	// Floor of a negative mean: negate the rounded-up quotient
	assign q_low     = dvd_q[MEAN_W-1:0];
	assign q_up      = q_low + MEAN_W'(drem_q != '0);
	assign mean_next = neg_q ? (~q_up + MEAN_W'(1)) : q_low;

	// Shared add/subtract unit; carry out on subtract means a >= b
	assign alu_y  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (ALU_W + 1)'(alu_sub);
	assign alu_ge = alu_y[ALU_W];

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			F_MUL_A: begin
				alu_a = ALU_W'({acc_q[P_W-2:0], 1'b0});
				alu_b = mplr_q[MAG_W-1] ? ALU_W'(s2) : '0;
			end
			F_MUL_B: begin
				alu_a = ALU_W'({acc_q[P_W-2:0], 1'b0});
				alu_b = mplr_q[MAG_W-1] ? ALU_W'(mag_q) : '0;
			end
			F_DIFF: begin
				alu_a   = ALU_W'(a_q);
				alu_b   = ALU_W'(acc_q);
				alu_sub = 1'b1;
			end
			F_SQRT: begin
				alu_a   = ALU_W'(rem_sh);
				alu_b   = ALU_W'(trial);
				alu_sub = 1'b1;
			end
			F_DIV_M, F_DIV_S: begin
				alu_a   = ALU_W'(drem_sh);
				alu_b   = ALU_W'(dvs_q);
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q || state_q == F_IDLE)
				step_q <= '0;
			else
				step_q <= step_q + STEP_W'(1);
		end
	end

	// Next state
	always_comb begin
		state_d  = state_q;
		step_end = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (start)
					state_d = F_MUL_A;
			end
			F_MUL_A: begin
				step_end = (step_q == LAST_MUL_A);
				if (step_end)
					state_d = F_MUL_B;
			end
			F_MUL_B: begin
				step_end = (step_q == LAST_MUL_B);
				if (step_end)
					state_d = F_DIFF;
			end
			F_DIFF: begin
				state_d = F_SQRT;
			end
			F_SQRT: begin
				step_end = (step_q == LAST_SQRT);
				if (step_end)
					state_d = F_DIV_M;
			end
			F_DIV_M: begin
				step_end = (step_q == LAST_DIV);
				if (step_end)
					state_d = F_FIX_M;
			end
			F_FIX_M: begin
				state_d = F_DIV_S;
			end
			F_DIV_S: begin
				step_end = (step_q == LAST_DIV);
				if (step_end)
					state_d = F_DONE;
			end
			F_DONE: begin
				state_d = F_IDLE;
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (start) begin
					mag_q  <= mag_in;
					neg_q  <= s1[S1_W-1];
					acc_q  <= '0;
					mplr_q <= {s0, {(MAG_W - S0_W){1'b0}}};
				end
			end
			F_MUL_A: begin
				if (step_end) begin
					a_q    <= alu_y[P_W-1:0];
					acc_q  <= '0;
					mplr_q <= mag_q;
				end else begin
					acc_q  <= alu_y[P_W-1:0];
					mplr_q <= mplr_q << 1;
				end
			end
			F_MUL_B: begin
				acc_q  <= alu_y[P_W-1:0];
				mplr_q <= mplr_q << 1;
			end
			F_DIFF: begin
				// Clamp a negative variance to zero
				x_q    <= alu_ge ? X_W'({alu_y[P_W-1:0], {SD_FRAC_SHIFT{1'b0}}}) : '0;
				rem_q  <= '0;
				root_q <= '0;
			end
			F_SQRT: begin
				rem_q  <= alu_ge ? alu_y[R_W+1:0] : rem_sh;
				root_q <= {root_q[R_W-2:0], alu_ge};
				x_q    <= x_q << 2;
				if (step_end) begin
					dvd_q  <= DVD_W'({mag_q, {MEAN_FRAC_SHIFT{1'b0}}});
					drem_q <= '0;
					dvs_q  <= DVS_W'(s0);
				end
			end
			F_DIV_M, F_DIV_S: begin
				drem_q <= alu_ge ? alu_y[REM_W-1:0] : drem_sh;
				dvd_q  <= {dvd_q[DVD_W-2:0], alu_ge};
			end
			F_FIX_M: begin
				mean_q <= mean_next;
				dvd_q  <= DVD_W'(root_q);
				drem_q <= '0;
				dvs_q  <= {s0, 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign done      = (state_q == F_DONE);
	assign mean_q8   = mean_q;
	assign stddev_q8 = dvd_q[SD_W-1:0];

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == F_IDLE)
		else $error("finish started while busy");

	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_SQRT |-> rem_q <= {1'b0, root_q, 1'b0})
		else $error("square root remainder out of bound");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV_M || state_q == F_DIV_S) |-> drem_q < REM_W'(dvs_q))
		else $error("division remainder not below divisor");

endmodule

>>> rtl/grouped_stddev_accumulator.sv
// Top level of the grouped standard deviation accumulator.
// Depends on gsa_pkg, gsa_chan_if and gsa_finish.
//
// Takes one frequency-table class per transaction and accumulates S0 = sum f,
// S1 = sum f*d and S2 = sum f*d*d with d = lower + upper, using one 34 x 17
// signed multiplier three times per class: each class occupies the input for
// the accept plus four multiply/accumulate steps. A class marked last then runs
// the end-of-series arithmetic on a shared add/subtract unit: shift-add
// products S0*S2 and S1*S1, a two-bit-per-step square root and two restoring
// divisions. A result carries the Q.8 mean and standard deviation and a status:
// too many classes or zero total frequency return zeros in both fields without
// the long computation. The sums clear when the result is written to the output
// register, which holds it until taken while the next series already enters.
module grouped_stddev_accumulator #(
	parameter int MAX_CLASSES = gsa_pkg::MAX_CLASSES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	gsa_chan_if.sink    samples,
	gsa_chan_if.source  stats
);
	import gsa_pkg::*;

	localparam int LOG_W  = $clog2(MAX_CLASSES);
	localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
	localparam int S0_W   = IN_W + LOG_W;
	localparam int S1_W   = 2 * IN_W + 1 + LOG_W;
	localparam int S2_W   = 3 * IN_W + 1 + LOG_W;
	localparam int FD_W   = 2 * IN_W + 1;
	localparam int FDD_W  = 3 * IN_W + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLASSES);

	acc_state_t state_q, state_d;

	logic signed [D_W-1:0] d_q;
	logic [IN_W-1:0]       f_q;
	logic                  last_q;

	logic [S0_W-1:0]        s0_q;
	logic signed [S1_W-1:0] s1_q;
	logic [S2_W-1:0]        s2_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   ovf_q;
	status_t                status_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [MUL_P_W-1:0] mul_q;

	result_t res_q;
	logic    res_valid_q;

	logic accept;
	logic at_limit;
	logic emit_go;
	logic fin_start;
	logic fin_done;
	logic signed [MEAN_W-1:0] fin_mean;
	logic [SD_W-1:0]          fin_sd;

	assign samples.ready = (state_q == A_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign at_limit      = (cnt_q == CNT_MAX);
	assign emit_go       = (state_q == A_EMIT) && (!res_valid_q || stats.ready);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= A_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and finish launch
	always_comb begin
		state_d   = state_q;
		fin_start = 1'b0;
		case (state_q)
			A_IDLE: begin
				if (accept) begin
					if (!at_limit)
						state_d = A_FD;
					else if (samples.data.last_class)
						state_d = A_EMIT;
				end
			end
			A_FD: state_d = A_SQ;
			A_SQ: state_d = A_FDD;
			A_FDD: state_d = A_S2;
			A_S2: begin
				if (!last_q) begin
					state_d = A_IDLE;
				end else if (ovf_q || s0_q == '0) begin
					state_d = A_EMIT;
				end else begin
					fin_start = 1'b1;
					state_d   = A_FIN;
				end
			end
			A_FIN: begin
				if (fin_done)
					state_d = A_EMIT;
			end
			A_EMIT: begin
				if (emit_go)
					state_d = A_IDLE;
			end
			default: state_d = A_IDLE;
		endcase
	end

	// Shared multiplier operands: f*d, then d*d, then f*(d*d)
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			A_FD: begin
				mul_a = MUL_A_W'(d_q);
				mul_b = $signed({1'b0, f_q});
			end
			A_SQ: begin
				mul_a = MUL_A_W'(d_q);
				mul_b = d_q;
			end
			A_FDD: begin
				mul_a = $signed(mul_q[MUL_A_W-1:0]);
				mul_b = $signed({1'b0, f_q});
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Capture the class and the multiplier product
	always_ff @(posedge clk) begin
		if (accept) begin
			d_q    <= D_W'(samples.data.class_lo) + D_W'(samples.data.class_hi);
			f_q    <= samples.data.frequency;
			last_q <= samples.data.last_class;
		end
		if (state_q == A_FD || state_q == A_SQ || state_q == A_FDD)
			mul_q <= mul_p;
	end

	// Accumulate sums; clear them once the result is written to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_q     <= '0;
			s1_q     <= '0;
			s2_q     <= '0;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			status_q <= STAT_OK;
		end else begin
			if (accept && at_limit) begin
				ovf_q    <= 1'b1;
				status_q <= STAT_OVERFLOW;
			end
			if (state_q == A_FD)
				s0_q <= s0_q + S0_W'(f_q);
			if (state_q == A_SQ)
				s1_q <= s1_q + S1_W'($signed(mul_q[FD_W-1:0]));
			if (state_q == A_S2) begin
				s2_q  <= s2_q + S2_W'(mul_q[FDD_W-1:0]);
				cnt_q <= cnt_q + CNT_W'(1);
				if (ovf_q)
					status_q <= STAT_OVERFLOW;
				else if (s0_q == '0)
					status_q <= STAT_ZERO_FREQ;
				else
					status_q <= STAT_OK;
			end
			if (emit_go) begin
				s0_q  <= '0;
				s1_q  <= '0;
				s2_q  <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (emit_go)
			res_valid_q <= 1'b1;
		else if (stats.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_q.mean_q8   <= (status_q == STAT_OK) ? fin_mean : '0;
			res_q.stddev_q8 <= (status_q == STAT_OK) ? fin_sd : '0;
			res_q.status    <= status_q;
		end
	end

	assign stats.valid = res_valid_q;
	assign stats.data  = res_q;

	gsa_finish #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (fin_start),
		.s0        (s0_q),
		.s1        (s1_q),
		.s2        (s2_q),
		.done      (fin_done),
		.mean_q8   (fin_mean),
		.stddev_q8 (fin_sd)
	);

	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		fin_done |-> state_q == A_FIN)
		else $error("finish completed while not awaited");

	a_ovf_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> cnt_q == CNT_MAX)
		else $error("overflow flagged below class limit");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (s0_q == '0 && s1_q == '0 && s2_q == '0 && cnt_q == '0 && !ovf_q))
		else $error("sums not cleared after result");

	a_error_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != STAT_OK) |->
			(res_q.mean_q8 == '0 && res_q.stddev_q8 == '0))
		else $error("error result with nonzero fields");

endmodule

>>> bench/gsa_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the grouped standard deviation accumulator bench.
// Watches the class and result channels, predicts each series result and compares it.
// Depends on gsa_pkg for the payload types and status codes.
module gsa_checker #(
	parameter int MAX_CLASSES = gsa_pkg::MAX_CLASSES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  gsa_pkg::class_t  in_class,
	input  logic             out_valid,
	input  logic             out_ready,
	input  gsa_pkg::result_t out_stats,
	output int               fail_count,
	output int               pending
);
	import gsa_pkg::*;

	// Running sums of the open series
	longint unsigned freq_sum;
	longint          mid_sum;
	longint unsigned sq_sum;
	int unsigned     class_cnt;
	bit              class_overflow;

	result_t expected_stats[$];
	result_t want;
	int      mismatches;

	function automatic void clear_sums();
		freq_sum       = 0;
		mid_sum        = 0;
		sq_sum         = 0;
		class_cnt      = 0;
		class_overflow = 1'b0;
	endfunction

	// Mean and standard deviation of the closed series, Q.8, floored
	function automatic result_t series_stats();
		logic [127:0]    wide_s0, wide_s2, wide_mag, prod_a, prod_b, rad, wide_c, trial;
		logic [63:0]     root, cand, sd;
		longint unsigned mag, num, s0;
		longint          m;
		result_t         r;
		r = '0;
		if (class_overflow) begin
			r.status = STAT_OVERFLOW;
		end else if (freq_sum == 0) begin
			r.status = STAT_ZERO_FREQ;
		end else begin
			s0  = freq_sum;
			mag = (mid_sum < 0) ? longint'(-mid_sum) : mid_sum;
			num = mag << MEAN_FRAC_SHIFT;
			// Round toward minus infinity for a negative mean
			if (mid_sum < 0)
				m = -longint'((num + s0 - 1) / s0);
			else
				m = longint'(num / s0);
			// Variance numerator S0*S2 - S1*S1, clamped at zero, then scaled
			wide_s0  = s0;
			wide_s2  = sq_sum;
			wide_mag = mag;
			prod_a   = wide_s0 * wide_s2;
			prod_b   = wide_mag * wide_mag;
			rad      = (prod_a > prod_b) ? (prod_a - prod_b) << SD_FRAC_SHIFT : '0;
			// Bitwise integer square root
			root = '0;
			for (int b = 63; b >= 0; b--) begin
				cand    = root;
				cand[b] = 1'b1;
				wide_c  = cand;
				trial   = wide_c * wide_c;
				if (trial <= rad)
					root = cand;
			end
			sd          = root / (64'd2 * s0);
			r.status    = STAT_OK;
			r.mean_q8   = m[MEAN_W-1:0];
			r.stddev_q8 = sd[SD_W-1:0];
		end
		return r;
	endfunction

	// Fold one class into the sums; close the series on the last class
	function automatic void fold_class(class_t c);
		longint d, f;
		d = longint'($signed(c.class_lo)) + longint'($signed(c.class_hi));
		f = longint'(c.frequency);
		if (class_cnt >= MAX_CLASSES) begin
			class_overflow = 1'b1;
		end else begin
			freq_sum += f;
			mid_sum  += f * d;
			sq_sum   += f * d * d;
			class_cnt++;
		end
		if (c.last_class) begin
			expected_stats.push_back(series_stats());
			clear_sums();
		end
	endfunction

	// Compare each result transaction, then fold each class transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_sums();
			expected_stats.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_stats.size() == 0) begin
					$error("unexpected result: mean_q8 %0d stddev_q8 %0d status %0d",
						out_stats.mean_q8, out_stats.stddev_q8, out_stats.status);
					mismatches++;
				end else begin
					want = expected_stats.pop_front();
					if (out_stats.mean_q8 !== want.mean_q8) begin
						$error("mean_q8 mismatch: expected %0d, actual %0d",
							want.mean_q8, out_stats.mean_q8);
						mismatches++;
					end
					if (out_stats.stddev_q8 !== want.stddev_q8) begin
						$error("stddev_q8 mismatch: expected %0d, actual %0d",
							want.stddev_q8, out_stats.stddev_q8);
						mismatches++;
					end
					if (out_stats.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, out_stats.status);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				fold_class(in_class);
			fail_count <= mismatches;
			pending    <= expected_stats.size();
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the grouped standard deviation accumulator bench: clock, reset and stimulus.
// Depends on gsa_pkg, gsa_chan_if, the block itself and gsa_checker.
module tb_top;
	import gsa_pkg::*;

	localparam int          MAX_CLS      = MAX_CLASSES_DEF;
	localparam int          CLK_PERIOD   = 10;
	localparam int          RANDOM_ITEMS = 1400;
	localparam int          HOLD_CYCLES  = 3000;
	localparam int          DRAIN_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT  = 1500000;

	typedef enum int {
		MIX_FULL,
		MIX_SMALL,
		MIX_EXTREME,
		MIX_ZERO
	} mix_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	bit          tx_burst;
	int          fail_count;
	int          pending;
	int unsigned cycle_count = 0;

	gsa_chan_if #(.payload_t(class_t))  samples_if ();
	gsa_chan_if #(.payload_t(result_t)) stats_if ();

	grouped_stddev_accumulator #(
		.MAX_CLASSES(MAX_CLS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.stats   (stats_if)
	);

	gsa_checker #(
		.MAX_CLASSES(MAX_CLS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (samples_if.valid),
		.in_ready   (samples_if.ready),
		.in_class   (samples_if.data),
		.out_valid  (stats_if.valid),
		.out_ready  (stats_if.ready),
		.out_stats  (stats_if.data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic mix_t pick_mix();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return MIX_FULL;
		else if (r < 15)
			return MIX_SMALL;
		else if (r < 18)
			return MIX_EXTREME;
		return MIX_ZERO;
	endfunction

	function automatic int pick_limit(mix_t mix);
		case (mix)
			MIX_SMALL: begin
				return $urandom_range(0, 40) - 20;
			end
			MIX_EXTREME: begin
				case ($urandom_range(0, 3))
					0:       return -32768;
					1:       return 32767;
					2:       return 0;
					default: return -1;
				endcase
			end
			default: begin
				return $urandom_range(0, 65535) - 32768;
			end
		endcase
	endfunction

	function automatic int pick_freq(mix_t mix);
		case (mix)
			MIX_SMALL: begin
				return $urandom_range(0, 5);
			end
			MIX_EXTREME: begin
				case ($urandom_range(0, 2))
					0:       return 0;
					1:       return 1;
					default: return 65535;
				endcase
			end
			MIX_ZERO: begin
				return 0;
			end
			default: begin
				return $urandom_range(0, 65535);
			end
		endcase
	endfunction

	// Offer one class after a random gap (none in a burst) and hold it until the transaction completes
	task automatic offer_class(input int lo, input int hi, input int f, input bit last);
		int     gap;
		class_t c;
		gap = tx_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		c.class_lo   = lo[15:0];
		c.class_hi   = hi[15:0];
		c.frequency  = f[15:0];
		c.last_class = last;
		samples_if.data  <= c;
		samples_if.valid <= 1'b1;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Take results with random stalls and one long hold-off
	initial begin : result_sink
		int gap;
		int taken;
		bit rx_burst;
		taken    = 0;
		rx_burst = 1'b0;
		stats_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken % 8 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
			gap = rx_burst ? 0 : $urandom_range(0, 5);
			if (taken == 4)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				stats_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			stats_if.ready <= 1'b1;
			@(posedge clk);
			while (!stats_if.valid) @(posedge clk);
			@(negedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		int   rand_items;
		int   series_no;
		int   len;
		mix_t mix;
		samples_if.valid = 1'b0;
		samples_if.data  = '0;
		tx_burst         = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single class at the origin
		offer_class(0, 0, 1, 1'b1);
		// Zero total frequency
		offer_class(5, 7, 0, 1'b1);
		// Widest spread between the extreme midpoints
		offer_class(-32768, -32768, 65535, 1'b0);
		offer_class(32767, 32767, 65535, 1'b1);
		// Lower above upper, with a negative and a positive sum
		offer_class(32767, -32768, 65535, 1'b1);
		offer_class(100, -50, 3, 1'b1);
		// Negative mean that needs rounding down
		offer_class(-1, 0, 1, 1'b0);
		offer_class(0, 0, 2, 1'b1);
		// Zero-frequency classes inside a series
		offer_class(10, 20, 0, 1'b0);
		offer_class(10, 20, 0, 1'b0);
		offer_class(1, 3, 4, 1'b1);
		// Mixed series
		offer_class(-32768, 32767, 1, 1'b0);
		offer_class(0, 1, 65535, 1'b0);
		offer_class(-100, -200, 7, 1'b0);
		offer_class(3000, 3010, 250, 1'b1);
		// Lowest single midpoint
		offer_class(-32768, -32768, 65535, 1'b1);
		// Several zero-frequency classes only
		offer_class(1, 2, 0, 1'b0);
		offer_class(3, 4, 0, 1'b1);

		// Random series; a few run up to and past the class bound
		rand_items = 0;
		series_no  = 0;
		while (rand_items < RANDOM_ITEMS) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			mix      = pick_mix();
			if (series_no == 6) begin
				len = MAX_CLS;
				mix = MIX_FULL;
			end else if (series_no == 20) begin
				len = MAX_CLS + 1;
				mix = MIX_FULL;
			end else if (series_no == 40) begin
				// Overflow must win over zero frequency
				len = MAX_CLS + 1 + $urandom_range(0, 30);
				mix = MIX_ZERO;
			end else if ($urandom_range(0, 11) == 0) begin
				len = $urandom_range(9, 40);
			end else begin
				len = $urandom_range(1, 8);
			end
			for (int k = 0; k < len; k++)
				offer_class(pick_limit(mix), pick_limit(mix), pick_freq(mix), k == len - 1);
			rand_items += len;
			series_no++;
		end
		samples_if.valid <= 1'b0;

		// Drain the outstanding results, then give stray ones time to show
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
